>>> sv/cpl_pkg.sv
// Shared constants and types for the closest-points core.
// No dependencies.
`default_nettype none
package cpl_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int DIR_WIDTH_DEF = 16;
	localparam int THR_WIDTH = 48;
	localparam int RES_WIDTH = 32;
	localparam int QUEUE_DEPTH = 8;
	localparam logic [THR_WIDTH-1:0] THR_RESET = 48'd72057594038;

	typedef logic [THR_WIDTH-1:0] thr_t;
	typedef logic signed [RES_WIDTH-1:0] res_t;
endpackage
`default_nettype wire

>>> sv/cpl_front.sv
// Front pipeline: forms w0, the dot products and the determinant, and flags parallel pairs.
// Depends on cpl_pkg.
`default_nettype none
module cpl_front #(
	parameter int CW = 32,
	parameter int DW = 16,
	parameter int IW = 1 + 3 * (2 * DW + 2) + 2 * (DW + CW + 3) + 2 * (2 * DW + 2) + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 take,
	input  wire logic signed [CW-1:0] p1x,
	input  wire logic signed [CW-1:0] p1y,
	input  wire logic signed [CW-1:0] p1z,
	input  wire logic signed [DW-1:0] d1x,
	input  wire logic signed [DW-1:0] d1y,
	input  wire logic signed [DW-1:0] d1z,
	input  wire logic signed [CW-1:0] p2x,
	input  wire logic signed [CW-1:0] p2y,
	input  wire logic signed [CW-1:0] p2z,
	input  wire logic signed [DW-1:0] d2x,
	input  wire logic signed [DW-1:0] d2y,
	input  wire logic signed [DW-1:0] d2z,
	input  wire cpl_pkg::thr_t        thr,
	output logic                      push,
	output logic [IW-1:0]             item
);
	import cpl_pkg::*;

	localparam int AW = 2 * DW + 2;
	localparam int EW = DW + CW + 3;
	localparam int DETW = 2 * AW + 1;
	localparam int CMPW = (DETW > THR_WIDTH) ? DETW : THR_WIDTH;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [CW-1:0] p1_s1 [3];
	logic signed [CW-1:0] p2_s1 [3];
	logic signed [DW-1:0] d1_s1 [3];
	logic signed [DW-1:0] d2_s1 [3];

	logic signed [CW:0]   w0_s2 [3];
	logic signed [DW-1:0] d1_s2 [3];
	logic signed [DW-1:0] d2_s2 [3];

	logic signed [2*DW-1:0]  aa_s3 [3];
	logic signed [2*DW-1:0]  bb_s3 [3];
	logic signed [2*DW-1:0]  cc_s3 [3];
	logic signed [DW+CW:0]   dd_s3 [3];
	logic signed [DW+CW:0]   ee_s3 [3];

	logic signed [AW-1:0] a_s4, b_s4, c_s4, a_s5, b_s5, c_s5, a_s6, b_s6, c_s6, a_s7, b_s7, c_s7;
	logic signed [EW-1:0] d_s4, e_s4, d_s5, e_s5, d_s6, e_s6, d_s7, e_s7;
	logic signed [2*AW-1:0] ac_s5, bsq_s5;
	logic signed [DETW-1:0] det_s6, det_s7;
	logic par_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		p1_s1[0] <= p1x;
		p1_s1[1] <= p1y;
		p1_s1[2] <= p1z;
		p2_s1[0] <= p2x;
		p2_s1[1] <= p2y;
		p2_s1[2] <= p2z;
		d1_s1[0] <= d1x;
		d1_s1[1] <= d1y;
		d1_s1[2] <= d1z;
		d2_s1[0] <= d2x;
		d2_s1[1] <= d2y;
		d2_s1[2] <= d2z;
		for (int i = 0; i < 3; i++) begin
			w0_s2[i] <= (CW+1)'(p1_s1[i]) - (CW+1)'(p2_s1[i]);
			d1_s2[i] <= d1_s1[i];
			d2_s2[i] <= d2_s1[i];
			aa_s3[i] <= (2*DW)'(d1_s2[i]) * (2*DW)'(d1_s2[i]);
			bb_s3[i] <= (2*DW)'(d1_s2[i]) * (2*DW)'(d2_s2[i]);
			cc_s3[i] <= (2*DW)'(d2_s2[i]) * (2*DW)'(d2_s2[i]);
			dd_s3[i] <= (DW+CW+1)'(d1_s2[i]) * (DW+CW+1)'(w0_s2[i]);
			ee_s3[i] <= (DW+CW+1)'(d2_s2[i]) * (DW+CW+1)'(w0_s2[i]);
		end
		a_s4 <= AW'(aa_s3[0]) + AW'(aa_s3[1]) + AW'(aa_s3[2]);
		b_s4 <= AW'(bb_s3[0]) + AW'(bb_s3[1]) + AW'(bb_s3[2]);
		c_s4 <= AW'(cc_s3[0]) + AW'(cc_s3[1]) + AW'(cc_s3[2]);
		d_s4 <= EW'(dd_s3[0]) + EW'(dd_s3[1]) + EW'(dd_s3[2]);
		e_s4 <= EW'(ee_s3[0]) + EW'(ee_s3[1]) + EW'(ee_s3[2]);
		ac_s5 <= (2*AW)'(a_s4) * (2*AW)'(c_s4);
		bsq_s5 <= (2*AW)'(b_s4) * (2*AW)'(b_s4);
		a_s5 <= a_s4;
		b_s5 <= b_s4;
		c_s5 <= c_s4;
		d_s5 <= d_s4;
		e_s5 <= e_s4;
		det_s6 <= DETW'(ac_s5) - DETW'(bsq_s5);
		a_s6 <= a_s5;
		b_s6 <= b_s5;
		c_s6 <= c_s5;
		d_s6 <= d_s5;
		e_s6 <= e_s5;
		par_s7 <= (det_s6 == '0) || (CMPW'($unsigned(det_s6)) < CMPW'(thr));
		det_s7 <= det_s6;
		a_s7 <= a_s6;
		b_s7 <= b_s6;
		c_s7 <= c_s6;
		d_s7 <= d_s6;
		e_s7 <= e_s6;
	end

	assign push = v_s7;
	assign item = {par_s7, a_s7, b_s7, c_s7, d_s7, e_s7, det_s7};
endmodule
`default_nettype wire

>>> sv/cpl_queue.sv
// Short queue between front and back; drains one entry per cycle.
// Depends on cpl_pkg.
`default_nettype none
module cpl_queue #(
	parameter int W = 8,
	parameter int DEPTH = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              out_vld,
	output logic [W-1:0]      rdata
);
	import cpl_pkg::*;

	localparam int PW = $clog2(DEPTH);

	logic [W-1:0] mem [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;
	logic pop;
	logic [W-1:0] rdata_q;
	logic out_vld_q;

	assign pop = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
		if (pop) begin
			rdata_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
			out_vld_q <= pop;
		end
	end

	assign out_vld = out_vld_q;
	assign rdata = rdata_q;
endmodule
`default_nettype wire

>>> sv/cpl_div.sv
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage,
// with round-to-nearest and saturation. Depends on cpl_pkg.
`default_nettype none
module cpl_div #(
	parameter int NW = 86,
	parameter int DENW = 69,
	parameter int FRAC = 14
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_vld,
	input  wire logic                 in_par,
	input  wire logic signed [NW-1:0] num1,
	input  wire logic signed [NW-1:0] num2,
	input  wire logic [DENW-1:0]      den,
	output logic                      out_vld,
	output logic                      out_valid_res,
	output cpl_pkg::res_t             q1,
	output cpl_pkg::res_t             q2
);
	import cpl_pkg::*;

	localparam int QW = RES_WIDTH;
	localparam int MW = NW + FRAC;
	localparam int RW = (MW > DENW + QW + 1) ? MW : DENW + QW + 1;

	logic signed [NW-1:0] num [2];
	logic [NW-1:0] absv [2];

	logic vld_sa, par_sa;
	logic [DENW-1:0] den_sa;
	logic neg_sa [2];
	logic [RW-1:0] mag_sa [2];
	logic [RW-1:0] ovf_lim;

	logic vld_s [QW+1];
	logic par_s [QW+1];
	logic [DENW-1:0] den_s [QW+1];
	logic [RW-1:0] rem_s [2][QW+1];
	logic [QW-1:0] quo_s [2][QW+1];
	logic neg_s [2][QW+1];
	logic ovf_s [2][QW+1];
	logic [RW-1:0] dsh_c [QW];
	logic ge_c [2][QW];
	logic rnd_c [2];

	logic vld_sc, par_sc;
	logic [QW:0] qr_sc [2];
	logic neg_sc [2];
	logic ovf_sc [2];
	logic [QW:0] lim_c [2];
	logic [QW-1:0] fin_c [2];

	logic vld_sd, valid_res_sd;
	logic [QW-1:0] res_sd [2];

	assign num[0] = num1;
	assign num[1] = num2;
	assign ovf_lim = RW'(den_sa) << QW;

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			absv[j] = num[j][NW-1] ? NW'(-num[j]) : NW'(num[j]);
		end
		for (int k = 0; k < QW; k++) begin
			dsh_c[k] = RW'(den_s[k]) << (QW - 1 - k);
			for (int j = 0; j < 2; j++) begin
				ge_c[j][k] = rem_s[j][k] >= dsh_c[k];
			end
		end
		for (int j = 0; j < 2; j++) begin
			rnd_c[j] = {rem_s[j][QW], 1'b0} >= (RW+1)'(den_s[QW]);
			lim_c[j] = neg_sc[j] ? ((QW+1)'(1) << (QW - 1))
				: (((QW+1)'(1) << (QW - 1)) - (QW+1)'(1));
			if (ovf_sc[j] || (qr_sc[j] > lim_c[j])) begin
				fin_c[j] = lim_c[j][QW-1:0];
			end else if (neg_sc[j]) begin
				fin_c[j] = -qr_sc[j][QW-1:0];
			end else begin
				fin_c[j] = qr_sc[j][QW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			for (int k = 0; k <= QW; k++) begin
				vld_s[k] <= 1'b0;
			end
			vld_sc <= 1'b0;
			vld_sd <= 1'b0;
		end else begin
			vld_sa <= in_vld;
			vld_s[0] <= vld_sa;
			for (int k = 0; k < QW; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			vld_sc <= vld_s[QW];
			vld_sd <= vld_sc;
		end
	end

	always_ff @(posedge clk) begin
		par_sa <= in_par;
		den_sa <= den;
		par_s[0] <= par_sa;
		den_s[0] <= den_sa;
		for (int k = 0; k < QW; k++) begin
			par_s[k+1] <= par_s[k];
			den_s[k+1] <= den_s[k];
		end
		par_sc <= par_s[QW];
		for (int j = 0; j < 2; j++) begin
			neg_sa[j] <= num[j][NW-1];
			mag_sa[j] <= RW'(absv[j]) << FRAC;
			rem_s[j][0] <= mag_sa[j];
			quo_s[j][0] <= '0;
			neg_s[j][0] <= neg_sa[j];
			ovf_s[j][0] <= mag_sa[j] >= ovf_lim;
			for (int k = 0; k < QW; k++) begin
				rem_s[j][k+1] <= ge_c[j][k] ? rem_s[j][k] - dsh_c[k] : rem_s[j][k];
				quo_s[j][k+1] <= quo_s[j][k] | (ge_c[j][k] ? (QW'(1) << (QW - 1 - k)) : '0);
				neg_s[j][k+1] <= neg_s[j][k];
				ovf_s[j][k+1] <= ovf_s[j][k];
			end
			qr_sc[j] <= (QW+1)'(quo_s[j][QW]) + (QW+1)'(rnd_c[j]);
			neg_sc[j] <= neg_s[j][QW];
			ovf_sc[j] <= ovf_s[j][QW];
			res_sd[j] <= par_sc ? '0 : fin_c[j];
		end
		valid_res_sd <= !par_sc;
	end

	assign out_vld = vld_sd;
	assign out_valid_res = valid_res_sd;
	assign q1 = res_sd[0];
	assign q2 = res_sd[1];
endmodule
`default_nettype wire

>>> sv/cpl_back.sv
// Back pipeline: numerator products split into partial products, then the divider.
// Depends on cpl_pkg and cpl_div.
`default_nettype none
module cpl_back #(
	parameter int CW = 32,
	parameter int DW = 16,
	parameter int IW = 1 + 3 * (2 * DW + 2) + 2 * (DW + CW + 3) + 2 * (2 * DW + 2) + 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire logic [IW-1:0] item,
	output logic               done,
	output logic               valid_res,
	output cpl_pkg::res_t      first_param,
	output cpl_pkg::res_t      second_param
);
	import cpl_pkg::*;

	localparam int AW = 2 * DW + 2;
	localparam int EW = DW + CW + 3;
	localparam int DETW = 2 * AW + 1;
	localparam int LO = EW / 2;
	localparam int HI = EW - LO;
	localparam int PL = AW + LO + 1;
	localparam int PH = AW + HI;
	localparam int NPW = AW + EW;
	localparam int NW = AW + EW + 1;

	logic par_i;
	logic signed [AW-1:0] a_i, b_i, c_i;
	logic signed [EW-1:0] d_i, e_i;
	logic [DETW-1:0] det_i;
	logic signed [LO:0] e_lo, d_lo;
	logic signed [HI-1:0] e_hi, d_hi;

	logic v_s1, v_s2, v_s3;
	logic par_s1, par_s2, par_s3;
	logic [DETW-1:0] det_s1, det_s2, det_s3;
	logic signed [PL-1:0] bel_s1, cdl_s1, ael_s1, bdl_s1;
	logic signed [PH-1:0] beh_s1, cdh_s1, aeh_s1, bdh_s1;
	logic signed [NPW-1:0] be_s2, cd_s2, ae_s2, bd_s2;
	logic signed [NW-1:0] n1_s3, n2_s3;

	assign {par_i, a_i, b_i, c_i, d_i, e_i, det_i} = item;
	assign e_lo = $signed({1'b0, e_i[LO-1:0]});
	assign d_lo = $signed({1'b0, d_i[LO-1:0]});
	assign e_hi = $signed(e_i[EW-1:LO]);
	assign d_hi = $signed(d_i[EW-1:LO]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		bel_s1 <= PL'(b_i) * PL'(e_lo);
		cdl_s1 <= PL'(c_i) * PL'(d_lo);
		ael_s1 <= PL'(a_i) * PL'(e_lo);
		bdl_s1 <= PL'(b_i) * PL'(d_lo);
		beh_s1 <= PH'(b_i) * PH'(e_hi);
		cdh_s1 <= PH'(c_i) * PH'(d_hi);
		aeh_s1 <= PH'(a_i) * PH'(e_hi);
		bdh_s1 <= PH'(b_i) * PH'(d_hi);
		par_s1 <= par_i;
		det_s1 <= det_i;
		be_s2 <= (NPW'(beh_s1) <<< LO) + NPW'(bel_s1);
		cd_s2 <= (NPW'(cdh_s1) <<< LO) + NPW'(cdl_s1);
		ae_s2 <= (NPW'(aeh_s1) <<< LO) + NPW'(ael_s1);
		bd_s2 <= (NPW'(bdh_s1) <<< LO) + NPW'(bdl_s1);
		par_s2 <= par_s1;
		det_s2 <= det_s1;
		n1_s3 <= NW'(be_s2) - NW'(cd_s2);
		n2_s3 <= NW'(ae_s2) - NW'(bd_s2);
		par_s3 <= par_s2;
		det_s3 <= det_s2;
	end

	cpl_div #(
		.NW(NW),
		.DENW(DETW),
		.FRAC(DW - 2)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(v_s3),
		.in_par(par_s3),
		.num1(n1_s3),
		.num2(n2_s3),
		.den(det_s3),
		.out_vld(done),
		.out_valid_res(valid_res),
		.q1(first_param),
		.q2(second_param)
	);
endmodule
`default_nettype wire

>>> sv/closest_points_between_lines_core.sv
// Closest points between two 3D lines: one pair accepted per cycle, busy stays low in use.
// Throughput: one pair per cycle, set by the fully pipelined front, queue and divider,
// whose 32 quotient-bit stages each form one bit of the quotient.
// Reset clears all pipeline valids and the queue; the threshold register resets to about 1e-6.
// The receiver cannot stall; each result shows for one cycle with done.
// Depends on cpl_pkg, cpl_front, cpl_queue, cpl_back.
`default_nettype none
module closest_points_between_lines_core #(
	parameter int COORD_WIDTH = cpl_pkg::COORD_WIDTH_DEF,
	parameter int DIR_WIDTH = cpl_pkg::DIR_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          parallel_threshold_we,
	input  wire cpl_pkg::thr_t                 parallel_threshold_wdata,
	input  wire logic signed [COORD_WIDTH-1:0] first_start_x,
	input  wire logic signed [COORD_WIDTH-1:0] first_start_y,
	input  wire logic signed [COORD_WIDTH-1:0] first_start_z,
	input  wire logic signed [DIR_WIDTH-1:0]   first_dir_x,
	input  wire logic signed [DIR_WIDTH-1:0]   first_dir_y,
	input  wire logic signed [DIR_WIDTH-1:0]   first_dir_z,
	input  wire logic signed [COORD_WIDTH-1:0] second_start_x,
	input  wire logic signed [COORD_WIDTH-1:0] second_start_y,
	input  wire logic signed [COORD_WIDTH-1:0] second_start_z,
	input  wire logic signed [DIR_WIDTH-1:0]   second_dir_x,
	input  wire logic signed [DIR_WIDTH-1:0]   second_dir_y,
	input  wire logic signed [DIR_WIDTH-1:0]   second_dir_z,
	output logic                               done,
	output logic                               valid_res,
	output cpl_pkg::res_t                      first_param,
	output cpl_pkg::res_t                      second_param
);
	import cpl_pkg::*;

	localparam int AW = 2 * DIR_WIDTH + 2;
	localparam int EW = DIR_WIDTH + COORD_WIDTH + 3;
	localparam int IW = 1 + 3 * AW + 2 * EW + 2 * AW + 1;

	thr_t thr_q;
	logic take, push, q_vld;
	logic [IW-1:0] f_item, b_item;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else begin
			if (parallel_threshold_we) begin
				thr_q <= parallel_threshold_wdata;
			end
		end
	end

	cpl_front #(
		.CW(COORD_WIDTH),
		.DW(DIR_WIDTH),
		.IW(IW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.p1x(first_start_x),
		.p1y(first_start_y),
		.p1z(first_start_z),
		.d1x(first_dir_x),
		.d1y(first_dir_y),
		.d1z(first_dir_z),
		.p2x(second_start_x),
		.p2y(second_start_y),
		.p2z(second_start_z),
		.d2x(second_dir_x),
		.d2y(second_dir_y),
		.d2z(second_dir_z),
		.thr(thr_q),
		.push(push),
		.item(f_item)
	);

	cpl_queue #(
		.W(IW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(f_item),
		.out_vld(q_vld),
		.rdata(b_item)
	);

	cpl_back #(
		.CW(COORD_WIDTH),
		.DW(DIR_WIDTH),
		.IW(IW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(q_vld),
		.item(b_item),
		.done(done),
		.valid_res(valid_res),
		.first_param(first_param),
		.second_param(second_param)
	);
endmodule
`default_nettype wire

>>> bench/closest_points_between_lines_core_tb.sv
// Testbench for closest_points_between_lines_core: drives line pairs, predicts
// the line parameters with wide integer arithmetic and checks every result.
// Depends on cpl_pkg and closest_points_between_lines_core.
`timescale 1ns / 100ps
module closest_points_between_lines_core_tb;
	import cpl_pkg::*;

	localparam int LATENCY = 48;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic signed [31:0] p1 [3];
		logic signed [15:0] d1 [3];
		logic signed [31:0] p2 [3];
		logic signed [15:0] d2 [3];
	} line_pair_t;

	typedef struct {
		logic valid;
		res_t t1;
		res_t t2;
	} params_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic parallel_threshold_we = 1'b0;
	thr_t parallel_threshold_wdata = '0;
	logic signed [31:0] first_start_x = '0, first_start_y = '0, first_start_z = '0;
	logic signed [15:0] first_dir_x = '0, first_dir_y = '0, first_dir_z = '0;
	logic signed [31:0] second_start_x = '0, second_start_y = '0, second_start_z = '0;
	logic signed [15:0] second_dir_x = '0, second_dir_y = '0, second_dir_z = '0;
	logic done;
	logic valid_res;
	res_t first_param;
	res_t second_param;

	thr_t threshold;
	params_t expected_params [$];
	int mismatches = 0;
	int pairs_sent = 0;
	int results_seen = 0;
	int parallel_seen = 0;
	int idle_pct = 29;
	int watchdog = 0;

	closest_points_between_lines_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.parallel_threshold_we(parallel_threshold_we),
		.parallel_threshold_wdata(parallel_threshold_wdata),
		.first_start_x(first_start_x), .first_start_y(first_start_y),
		.first_start_z(first_start_z), .first_dir_x(first_dir_x),
		.first_dir_y(first_dir_y), .first_dir_z(first_dir_z),
		.second_start_x(second_start_x), .second_start_y(second_start_y),
		.second_start_z(second_start_z), .second_dir_x(second_dir_x),
		.second_dir_y(second_dir_y), .second_dir_z(second_dir_z),
		.done(done), .valid_res(valid_res),
		.first_param(first_param), .second_param(second_param)
	);

	always #5 clk = ~clk;

	function automatic res_t round_quotient(logic signed [255:0] num, logic signed [255:0] den);
		logic [255:0] mag;
		logic [255:0] q;
		logic [255:0] r;
		logic neg;
		neg = num[255];
		mag = neg ? -num : num;
		mag = mag << 14;
		q = mag / den;
		r = mag % den;
		if ((r << 1) >= den)
			q = q + 1;
		if (neg) begin
			if (q >= 256'h8000_0000)
				return 32'sh8000_0000;
			return -q[31:0];
		end
		if (q > 256'h7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic params_t closest_params(line_pair_t lp, thr_t thr);
		logic signed [255:0] w [3];
		logic signed [255:0] u [3];
		logic signed [255:0] v [3];
		logic signed [255:0] a, b, c, d, e, det;
		params_t res;
		a = 0; b = 0; c = 0; d = 0; e = 0;
		for (int i = 0; i < 3; i++) begin
			w[i] = 256'(lp.p1[i]) - 256'(lp.p2[i]);
			u[i] = 256'(lp.d1[i]);
			v[i] = 256'(lp.d2[i]);
			a += u[i] * u[i];
			b += u[i] * v[i];
			c += v[i] * v[i];
			d += u[i] * w[i];
			e += v[i] * w[i];
		end
		det = a * c - b * b;
		if (det == 0 || det < $signed({208'd0, thr})) begin
			res = '{1'b0, '0, '0};
			return res;
		end
		res.valid = 1'b1;
		res.t1 = round_quotient(b * e - c * d, det);
		res.t2 = round_quotient(a * e - b * d, det);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		params_t want;
		if (arst_n && done) begin
			results_seen++;
			if (expected_params.size() == 0) begin
				report_mismatch("unexpected result", first_param, '0);
			end else begin
				want = expected_params.pop_front();
				if (!want.valid)
					parallel_seen++;
				if (valid_res !== want.valid)
					report_mismatch("valid_res", valid_res, want.valid);
				if (first_param !== want.t1)
					report_mismatch("first_param", first_param, want.t1);
				if (second_param !== want.t2)
					report_mismatch("second_param", second_param, want.t2);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || parallel_threshold_we)
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("timeout waiting for transfer");
			$display("closest_points_between_lines_core_tb: FAIL");
			$finish;
		end
	end

	task automatic send_pair(line_pair_t lp);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		{first_start_x, first_start_y, first_start_z} <= {lp.p1[0], lp.p1[1], lp.p1[2]};
		{first_dir_x, first_dir_y, first_dir_z} <= {lp.d1[0], lp.d1[1], lp.d1[2]};
		{second_start_x, second_start_y, second_start_z} <= {lp.p2[0], lp.p2[1], lp.p2[2]};
		{second_dir_x, second_dir_y, second_dir_z} <= {lp.d2[0], lp.d2[1], lp.d2[2]};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_params.push_back(closest_params(lp, threshold));
		pairs_sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (expected_params.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_threshold(thr_t value);
		drain();
		parallel_threshold_we <= 1'b1;
		parallel_threshold_wdata <= value;
		@(negedge clk);
		parallel_threshold_we <= 1'b0;
		threshold = value;
	endtask

	function automatic logic signed [15:0] rand_dir(int span);
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: return 16'sh7FFF;
			2: return 16'sh8000;
			default: return 16'($signed($urandom_range(2 * span)) - span);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
		endcase
	endfunction

	function automatic line_pair_t random_pair();
		line_pair_t lp;
		int span;
		span = 1 << $urandom_range(14, 4);
		for (int i = 0; i < 3; i++) begin
			lp.p1[i] = rand_coord();
			lp.p2[i] = rand_coord();
			lp.d1[i] = rand_dir(span);
			lp.d2[i] = rand_dir(span);
		end
		if ($urandom_range(9) == 0)
			lp.d2 = lp.d1;
		else if ($urandom_range(19) == 0)
			for (int i = 0; i < 3; i++)
				lp.d2[i] = lp.d1[i] + 16'($signed($urandom_range(2)) - 1);
		return lp;
	endfunction

	function automatic line_pair_t make_pair(logic signed [31:0] p, logic signed [15:0] d1x,
			logic signed [15:0] d1y, logic signed [15:0] d2x, logic signed [15:0] d2z);
		line_pair_t lp;
		lp.p1 = '{p, -p, 32'sh0001_0000};
		lp.p2 = '{-p, 32'sh0002_0000, p};
		lp.d1 = '{d1x, d1y, 16'sh0000};
		lp.d2 = '{d2x, 16'sh0000, d2z};
		return lp;
	endfunction

	task automatic test_directed;
		send_pair(make_pair(32'sh0001_0000, 16'sh4000, 16'sh0000, 16'sh0000, 16'sh4000));
		send_pair(make_pair(32'sh0000_0000, 16'sh0000, 16'sh0000, 16'sh4000, 16'sh0000));
		send_pair(make_pair(32'sh0003_0000, 16'sh4000, 16'sh4000, 16'sh4000, 16'sh0000));
		send_pair(make_pair(32'sh7FFF_FFFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF));
		send_pair(make_pair(32'sh8000_0000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000));
		send_pair(make_pair(32'sh7FFF_FFFF, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001));
		send_pair(make_pair(32'sh8000_0000, 16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001));
		send_pair(make_pair(32'sh0000_8000, 16'sh4000, 16'sh0000, 16'sh4000, 16'sh0000));
		send_pair(make_pair(32'shFFFF_FFFF, 16'shFFFF, 16'sh0001, 16'sh0001, 16'shFFFF));
		send_pair(make_pair(32'sh1234_5678, 16'sh2000, 16'shE000, 16'shC000, 16'sh3000));
	endtask

	task automatic test_thresholds;
		write_threshold('0);
		send_pair(make_pair(32'sh0001_0000, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001));
		send_pair(make_pair(32'sh0001_0000, 16'sh4000, 16'sh0000, 16'sh4000, 16'sh0000));
		write_threshold(48'd1);
		send_pair(make_pair(32'sh0001_0000, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001));
		write_threshold(48'd2);
		send_pair(make_pair(32'sh0001_0000, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001));
		write_threshold('1);
		send_pair(make_pair(32'sh0001_0000, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh7FFF));
		send_pair(make_pair(32'sh0001_0000, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh8000));
	endtask

	task automatic test_random(int count, thr_t thr);
		write_threshold(thr);
		for (int i = 0; i < count; i++) begin
			if (i >= count / 3 && i < count / 2)
				idle_pct = 0;
			else
				idle_pct = 29;
			send_pair(random_pair());
		end
	endtask

	initial begin
		threshold = THR_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_thresholds();
		test_random(400, THR_RESET);
		test_random(250, '0);
		test_random(250, 48'h0000_FFFF_FFFF);
		test_random(250, 48'($urandom) << $urandom_range(16));
		drain();
		$display("sent %0d line pairs, checked %0d results, %0d of them parallel",
			pairs_sent, results_seen, parallel_seen);
		if (mismatches == 0 && expected_params.size() == 0)
			$display("closest_points_between_lines_core_tb: PASS");
		else
			$display("closest_points_between_lines_core_tb: FAIL");
		$finish;
	end
endmodule
